FILE: hw/rtl/direct_mapped_read_cache_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef DIRECT_MAPPED_READ_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_READ_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dmrc_pkg.sv
// Types, constants and helpers of the direct-mapped read cache.
package dmrc_pkg;

    // Fixed field widths and default geometry.
    localparam int DMRC_ADDR_W      = 10;
    localparam int DMRC_PADDR_W     = 3;
    localparam int DMRC_BLOCK_BYTES = 8;
    localparam int DMRC_NUM_LINES   = 4;
    localparam int DMRC_MEM_BYTES   = 1024;

    localparam logic [7:0] HIT_COST_RESET     = 8'd1;
    localparam logic [7:0] MISS_PENALTY_RESET = 8'd10;
    localparam logic [31:0] SAT32             = 32'hFFFF_FFFF;

    // Command codes.
    localparam logic CMD_PRELOAD = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_HIT_COST     = 1'b0,
        REG_MISS_PENALTY = 1'b1
    } t_reg_idx;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_FILL
    } t_state;

    // One input beat.
    typedef struct packed {
        logic                   command;
        logic [DMRC_ADDR_W-1:0] address;
        logic [7:0]             write_byte;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic        was_hit;
        logic [7:0]  read_byte;
        logic [31:0] time_stamp;
        logic [31:0] miss_total;
    } t_out_item;

    // Saturating add of an 8-bit increment to a 32-bit counter.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [7:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {25'd0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

FILE: hw/rtl/dmrc_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module dmrc_ram import dmrc_pkg::*; #(
    parameter int DEPTH  = DMRC_NUM_LINES,
    parameter int DATA_W = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/direct_mapped_read_cache.sv
// A preload gives a registered result beat on acceptance; a hit first passes the lookup state,
// a miss the lookup and the line fill. A preload frees the command port at once, a hit after the
// lookup, a miss after the fill (it reads the byte-wide backing memory one byte per cycle).
// Reset: a clearing pass sweeps the tag memory line by line; busy stays high meanwhile.
// Backing memory has no reset. The result strobe lasts one cycle; the receiver cannot stall.
module direct_mapped_read_cache import dmrc_pkg::*; #(
    parameter int BLOCK_BYTES = DMRC_BLOCK_BYTES,
    parameter int NUM_LINES   = DMRC_NUM_LINES,
    parameter int MEM_BYTES   = DMRC_MEM_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Command channel.
    input  logic                    start,
    output logic                    busy,
    input  t_in_item                i_item,
    // Result channel.
    output logic                    o_result_valid,
    output t_out_item               o_result,
    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [DMRC_PADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    `include "direct_mapped_read_cache_defines.svh"

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int TAG_W  = (DMRC_ADDR_W > OFF_W + LINE_W) ? DMRC_ADDR_W - OFF_W - LINE_W : 1;
    localparam int AX_A   = (DMRC_ADDR_W > MEM_AW) ? DMRC_ADDR_W : MEM_AW;
    localparam int AX_W   = (AX_A > OFF_W + LINE_W) ? AX_A : OFF_W + LINE_W;
    localparam int DATA_DEPTH = NUM_LINES * BLOCK_BYTES;
    localparam logic [OFF_W-1:0]  LAST_OFF  = OFF_W'(BLOCK_BYTES - 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(NUM_LINES - 1);

    // Control registers.
    t_state            r_state, n_state;
    logic [OFF_W-1:0]  r_fill_cnt, n_fill_cnt;
    logic [LINE_W-1:0] r_clr_cnt, n_clr_cnt;
    logic [31:0]       r_time, n_time;
    logic [31:0]       r_miss, n_miss;
    logic              r_res_valid, n_res_valid;
    logic [7:0]        r_hit_cost, r_miss_penalty;
    // Payload registers.
    t_in_item          r_item;
    t_out_item         r_res, n_res;
    logic [7:0]        r_pick;

    // Address decomposition of the incoming and the held command.
    logic [AX_W-1:0]   in_ax, cur_ax, fill_ax;
    logic [LINE_W-1:0] in_line, cur_line;
    logic [OFF_W-1:0]  in_off, cur_off, fill_off;
    logic [TAG_W-1:0]  cur_tag;

    assign in_ax    = AX_W'(i_item.address);
    assign cur_ax   = AX_W'(r_item.address);
    assign in_line  = in_ax[OFF_W +: LINE_W];
    assign in_off   = in_ax[OFF_W-1:0];
    assign cur_line = cur_ax[OFF_W +: LINE_W];
    assign cur_off  = cur_ax[OFF_W-1:0];
    assign cur_tag  = TAG_W'(cur_ax >> (OFF_W + LINE_W));
    assign fill_ax  = {cur_ax[AX_W-1:OFF_W], fill_off};

    // Memory ports.
    logic              tag_we;
    logic [LINE_W-1:0] tag_waddr;
    logic [TAG_W:0]    tag_wdata, tag_rdata;
    logic              data_we;
    logic [7:0]        mem_rdata;
    logic              mem_we;
    logic              accept, lookup_hit, fill_last;
    logic [7:0]        fill_byte;

    assign accept     = start && !busy;
    assign lookup_hit = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == cur_tag);
    assign fill_last  = (r_fill_cnt == LAST_OFF);
    assign fill_byte  = (r_fill_cnt == cur_off) ? mem_rdata : r_pick;
    assign mem_we     = accept && (i_item.command == CMD_PRELOAD);
    assign data_we    = (r_state == S_FILL);

    // Tag and valid bit per line.
    dmrc_ram #(.DEPTH(NUM_LINES), .DATA_W(TAG_W + 1)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (in_line),
        .o_rdata (tag_rdata)
    );

    // Line bytes, addressed by line and offset.
    logic [7:0] data_rdata;
    dmrc_ram #(.DEPTH(DATA_DEPTH), .DATA_W(8)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr ({cur_line, r_fill_cnt}),
        .i_wdata (mem_rdata),
        .i_raddr ({in_line, in_off}),
        .o_rdata (data_rdata)
    );

    // Backing memory: preload writes, line fill reads.
    dmrc_ram #(.DEPTH(MEM_BYTES), .DATA_W(8)) u_backing_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (in_ax[MEM_AW-1:0]),
        .i_wdata (i_item.write_byte),
        .i_raddr (fill_ax[MEM_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == LAST_LINE) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && i_item.command == CMD_READ) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = lookup_hit ? S_IDLE : S_FILL;
            end
            S_FILL: begin
                if (fill_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs, memory controls and counter updates.
    always_comb begin
        busy        = 1'b1;
        tag_we      = 1'b0;
        tag_waddr   = cur_line;
        tag_wdata   = {1'b1, cur_tag};
        fill_off    = '0;
        n_fill_cnt  = r_fill_cnt;
        n_clr_cnt   = r_clr_cnt;
        n_time      = r_time;
        n_miss      = r_miss;
        n_res_valid = 1'b0;
        n_res       = r_res;
        unique case (r_state)
            S_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = r_clr_cnt;
                tag_wdata = '0;
                n_clr_cnt = r_clr_cnt + 1'b1;
            end
            S_IDLE: begin
                busy = 1'b0;
                // Busy is low here, so a start is an accepted beat.
                if (start && (i_item.command == CMD_PRELOAD)) begin
                    n_res_valid = 1'b1;
                    n_res       = '{was_hit: 1'b0, read_byte: 8'd0,
                                    time_stamp: r_time, miss_total: r_miss};
                end
            end
            S_LOOKUP: begin
                n_fill_cnt = '0;
                if (lookup_hit) begin
                    n_res_valid = 1'b1;
                    n_res       = '{was_hit: 1'b1, read_byte: data_rdata,
                                    time_stamp: r_time, miss_total: r_miss};
                    n_time      = sat_add32(r_time, r_hit_cost);
                end else begin
                    tag_we = 1'b1;
                    n_miss = sat_add32(r_miss, 8'd1);
                    n_time = sat_add32(r_time, r_miss_penalty);
                end
            end
            S_FILL: begin
                fill_off   = r_fill_cnt + 1'b1;
                n_fill_cnt = r_fill_cnt + 1'b1;
                if (fill_last) begin
                    n_res_valid = 1'b1;
                    n_res       = '{was_hit: 1'b0, read_byte: fill_byte,
                                    time_stamp: r_time, miss_total: r_miss};
                    n_time      = sat_add32(r_time, r_hit_cost);
                end
            end
            default: busy = 1'b1;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_fill_cnt  <= '0;
            r_clr_cnt   <= '0;
            r_time      <= '0;
            r_miss      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_cnt  <= n_fill_cnt;
            r_clr_cnt   <= n_clr_cnt;
            r_time      <= n_time;
            r_miss      <= n_miss;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload: held command, byte caught during the fill, result beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == S_FILL && r_fill_cnt == cur_off) begin
            r_pick <= mem_rdata;
        end
        r_res <= n_res;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cost     <= HIT_COST_RESET;
            r_miss_penalty <= MISS_PENALTY_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_HIT_COST:     r_hit_cost     <= pwdata[7:0];
                REG_MISS_PENALTY: r_miss_penalty <= pwdata[7:0];
                default:          r_hit_cost     <= r_hit_cost;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_HIT_COST:     prdata = {24'd0, r_hit_cost};
            REG_MISS_PENALTY: prdata = {24'd0, r_miss_penalty};
            default:          prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    // A hit in lookup delivers its beat in the next cycle.
    `DMRC_ASSERT_NEXT(a_hit_result, i_clk, i_rst_n, (r_state == S_LOOKUP) && lookup_hit,
        o_result_valid && o_result.was_hit, "hit did not deliver a result beat")
    // The miss count only moves in lookup.
    `DMRC_ASSERT_NEXT(a_miss_stable, i_clk, i_rst_n, r_state != S_LOOKUP,
        r_miss == $past(r_miss), "miss count changed outside lookup")
    // No tag write while a line fill is running.
    `DMRC_ASSERT_NOW(a_no_tag_write_in_fill, i_clk, i_rst_n, r_state == S_FILL,
        !tag_we && data_we, "tag written during line fill")

endmodule

FILE: tb/sv/direct_mapped_read_cache_tb.sv
// Self-checking testbench for the direct-mapped read cache: directed table, then random traffic.
`timescale 1ns / 1ps

module direct_mapped_read_cache_tb;
    import dmrc_pkg::*;

    localparam int DRAIN_CYCLES = DMRC_BLOCK_BYTES + 4;
    localparam int DIR_ROWS     = 23;
    localparam int NUM_BLOCKS   = DMRC_MEM_BYTES / DMRC_BLOCK_BYTES;

    // One row of the directed table; want is only used when typed is set.
    typedef struct packed {
        logic                   command;
        logic [DMRC_ADDR_W-1:0] address;
        logic [7:0]             write_byte;
        logic                   typed;
        t_out_item              want;
    } t_dir_row;

    localparam t_out_item NO_WANT = '0;

    // Two blocks are preloaded: block 0 and block 124, which shares line 0 with it.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{CMD_PRELOAD, 10'd0,   8'h00, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd1,   8'hFF, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd2,   8'h5A, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd3,   8'hA5, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd4,   8'h01, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd5,   8'h80, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd6,   8'h7F, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd7,   8'hFE, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd992, 8'h3C, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd993, 8'hC3, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd994, 8'h0F, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd995, 8'hF0, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd996, 8'hAA, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd997, 8'h55, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd998, 8'h81, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        '{CMD_PRELOAD, 10'd999, 8'h18, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd0}},
        // First read misses into an invalid line, the second hits.
        '{CMD_READ,    10'd0,   8'hFF, 1'b1, '{1'b0, 8'h00, 32'd10, 32'd1}},
        '{CMD_READ,    10'd7,   8'h00, 1'b1, '{1'b1, 8'hFE, 32'd11, 32'd1}},
        // A preload does not update the cached copy, so the next hit is stale.
        '{CMD_PRELOAD, 10'd0,   8'h33, 1'b1, '{1'b0, 8'h00, 32'd12, 32'd1}},
        '{CMD_READ,    10'd0,   8'h00, 1'b0, NO_WANT},
        // Conflict eviction on line 0, then a refill that sees the new byte.
        '{CMD_READ,    10'd999, 8'h00, 1'b0, NO_WANT},
        '{CMD_READ,    10'd1,   8'h00, 1'b0, NO_WANT},
        '{CMD_READ,    10'd0,   8'h00, 1'b0, NO_WANT}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    t_in_item                i_item;
    logic                    o_result_valid;
    t_out_item               o_result;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [DMRC_PADDR_W-1:0] paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    direct_mapped_read_cache dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Shadow copy of the cache, its backing memory and its counters.
    logic [7:0]  mem_image [DMRC_MEM_BYTES];
    logic [4:0]  shadow_tag [DMRC_NUM_LINES];
    logic        shadow_valid [DMRC_NUM_LINES] = '{default: 1'b0};
    logic [7:0]  shadow_line [DMRC_NUM_LINES][DMRC_BLOCK_BYTES];
    logic [31:0] access_time = '0;
    logic [31:0] miss_count  = '0;
    logic [7:0]  cfg_hit_cost     = HIT_COST_RESET;
    logic [7:0]  cfg_miss_penalty = MISS_PENALTY_RESET;

    // Results still owed by the cache, oldest first.
    t_out_item   pending_results [$];
    t_out_item   head_result;
    t_out_item   predicted;
    t_out_item   typed_result;
    logic        use_typed = 1'b0;
    int unsigned fail_count = 0;

    // Blocks whose eight bytes have all been preloaded, and the ones touched lately.
    bit          block_ready [NUM_BLOCKS];
    int unsigned ready_list [$];
    int unsigned recent_blocks [$];

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Applies one accepted beat to the shadow state and returns the result it owes.
    function automatic t_out_item predict_access(input t_in_item it);
        t_out_item  res;
        logic [1:0] ln;
        logic [4:0] tg;
        logic [2:0] off;
        int         k;
        res = '0;
        off = it.address[2:0];
        ln  = it.address[4:3];
        tg  = it.address[9:5];
        if (it.command == CMD_PRELOAD) begin
            mem_image[it.address] = it.write_byte;
        end else begin
            res.was_hit = shadow_valid[ln] && (shadow_tag[ln] == tg);
            if (!res.was_hit) begin
                miss_count = add_sat(miss_count, 32'd1);
                for (k = 0; k < DMRC_BLOCK_BYTES; k++) begin
                    shadow_line[ln][k] = mem_image[{it.address[9:3], 3'(k)}];
                end
                shadow_tag[ln]   = tg;
                shadow_valid[ln] = 1'b1;
                access_time      = add_sat(access_time, {24'd0, cfg_miss_penalty});
            end
            res.read_byte = shadow_line[ln][off];
        end
        res.time_stamp = access_time;
        res.miss_total = miss_count;
        // The hit cost is charged after the stamp is taken.
        if (it.command == CMD_READ) begin
            access_time = add_sat(access_time, {24'd0, cfg_hit_cost});
        end
        return res;
    endfunction

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compare each result beat with the oldest owed result, then log any accepted command.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no access outstanding");
                    fail_count++;
                end else begin
                    head_result = pending_results.pop_front();
                    if (o_result.was_hit !== head_result.was_hit) begin
                        $error("was_hit: expected %0d, got %0d",
                               head_result.was_hit, o_result.was_hit);
                        fail_count++;
                    end
                    if (o_result.read_byte !== head_result.read_byte) begin
                        $error("read_byte: expected 0x%02h, got 0x%02h",
                               head_result.read_byte, o_result.read_byte);
                        fail_count++;
                    end
                    if (o_result.time_stamp !== head_result.time_stamp) begin
                        $error("time_stamp: expected %0d, got %0d",
                               head_result.time_stamp, o_result.time_stamp);
                        fail_count++;
                    end
                    if (o_result.miss_total !== head_result.miss_total) begin
                        $error("miss_total: expected %0d, got %0d",
                               head_result.miss_total, o_result.miss_total);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                predicted = predict_access(i_item);
                pending_results.push_back(use_typed ? typed_result : predicted);
            end
        end
    end

    // Present one command beat and hold it until the cache takes it.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        @(negedge i_clk);
        start        <= 1'b1;
        i_item       <= it;
        use_typed    = typed;
        typed_result = want;
        do @(posedge i_clk); while (busy);
    endtask

    // Random sender gap before a beat, with junk on the command bus meanwhile.
    task automatic feed(input t_in_item it, input int unsigned idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= t_in_item'($bits(t_in_item)'($urandom));
            repeat ($urandom_range(7)) @(negedge i_clk);
        end
        send_item(it, 1'b0, NO_WANT);
    endtask

    // Stop sending and wait until every owed result has arrived.
    task automatic wait_drained(input int unsigned extra);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Register write followed by a read back over the APB port.
    task automatic cfg_write(input t_reg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_HIT_COST:     cfg_hit_cost     = val;
            REG_MISS_PENALTY: cfg_miss_penalty = val;
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'd0, val}) begin
            $error("prdata: expected 0x%08h, got 0x%08h", {24'd0, val}, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void note_recent(input int unsigned blk);
        recent_blocks.push_back(blk);
        if (recent_blocks.size() > 4) void'(recent_blocks.pop_front());
    endfunction

    // Mostly whole-block preloads followed by reads that cluster on recent blocks.
    task automatic run_random(input int unsigned n, input int unsigned idle_pct);
        int unsigned sent;
        int unsigned pick;
        int unsigned blk;
        int          k;
        t_in_item    it;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            it.write_byte = 8'($urandom);
            if (ready_list.size() == 0 || pick < 12) begin
                blk = $urandom_range(NUM_BLOCKS - 1);
                for (k = 0; k < DMRC_BLOCK_BYTES; k++) begin
                    it.command    = CMD_PRELOAD;
                    it.address    = {blk[6:0], 3'(k)};
                    it.write_byte = 8'($urandom);
                    feed(it, idle_pct);
                end
                if (!block_ready[blk]) begin
                    block_ready[blk] = 1'b1;
                    ready_list.push_back(blk);
                end
                note_recent(blk);
                sent += DMRC_BLOCK_BYTES;
            end else if (pick < 20) begin
                // Lone preload anywhere; it may leave a cached copy stale.
                it.command = CMD_PRELOAD;
                it.address = DMRC_ADDR_W'($urandom);
                feed(it, idle_pct);
                sent++;
            end else if (pick < 22) begin
                wait_drained(0);
            end else begin
                if ($urandom_range(99) < 70) begin
                    blk = recent_blocks[$urandom_range(recent_blocks.size() - 1)];
                end else begin
                    blk = ready_list[$urandom_range(ready_list.size() - 1)];
                end
                it.command = CMD_READ;
                it.address = {blk[6:0], 3'($urandom_range(DMRC_BLOCK_BYTES - 1))};
                feed(it, idle_pct);
                note_recent(blk);
                sent++;
            end
        end
    endtask

    // Sender idle percentage of each random phase.
    int unsigned phase_idle [4] = '{0, 83, 17, 0};

    initial begin
        int          r;
        int          p;
        logic [7:0]  hc;
        logic [7:0]  mp;
        t_in_item    it;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset configuration.
        for (r = 0; r < DIR_ROWS; r++) begin
            it.command    = DIR_TABLE[r].command;
            it.address    = DIR_TABLE[r].address;
            it.write_byte = DIR_TABLE[r].write_byte;
            send_item(it, DIR_TABLE[r].typed, DIR_TABLE[r].want);
        end
        block_ready[0]   = 1'b1;
        block_ready[124] = 1'b1;
        ready_list.push_back(0);
        ready_list.push_back(124);
        note_recent(0);
        note_recent(124);

        // Random phases, each under its own cost setting.
        for (p = 0; p < 4; p++) begin
            wait_drained(DRAIN_CYCLES);
            case (p)
                0:       begin hc = 8'd255; mp = 8'd255; end
                1:       begin hc = 8'd0;   mp = 8'd0;   end
                2:       begin hc = 8'($urandom); mp = 8'($urandom); end
                default: begin hc = 8'd0;   mp = 8'd255; end
            endcase
            cfg_write(REG_HIT_COST, hc);
            cfg_write(REG_MISS_PENALTY, mp);
            run_random(150, phase_idle[p]);
        end

        wait_drained(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/dmrc_pkg.sv
hw/rtl/dmrc_ram.sv
hw/rtl/direct_mapped_read_cache.sv
tb/sv/direct_mapped_read_cache_tb.sv
